// File: sv/pss_pkg.sv
`timescale 1ns / 1ps

package pss_pkg;

    // fixed field widths
    localparam int PIXEL_INDEX_W = 15;
    localparam int CODE_W        = 2;
    localparam int COLOR_W       = 32;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int SCALE_REG_W   = 4;
    localparam int PALETTE_SIZE  = 4;

    // item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // configuration register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WHITE = 3'd0,
        REG_LIGHT = 3'd1,
        REG_DARK  = 3'd2,
        REG_BLACK = 3'd3,
        REG_SCALE = 3'd4
    } cfg_reg_e_t;

    // register reset values
    localparam logic [COLOR_W-1:0] WHITE_RESET = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] LIGHT_RESET = 32'hFFAA_AAAA;
    localparam logic [COLOR_W-1:0] DARK_RESET  = 32'hFF55_5555;
    localparam logic [COLOR_W-1:0] BLACK_RESET = 32'hFF00_0000;
    localparam logic [SCALE_REG_W-1:0] SCALE_RESET = 4'd4;

    typedef struct packed {
        logic                     func;
        logic [PIXEL_INDEX_W-1:0] pixel_index;
        logic [CODE_W-1:0]        pixel_code;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               end_of_row;
        logic               end_of_frame;
    } out_item_t;

    // position flags of one fetched pixel
    typedef struct packed {
        logic end_of_row;
        logic end_of_frame;
    } scan_pos_t;

endpackage

// File: sv/palette_scanout_scaler.sv
`timescale 1ns / 1ps

// a fetch beat is registered in the memory read stage, then in the output register
// throughput: one beat per cycle while in_stall is low, writes and fetches alike; the
// screen memory has separate ports and takes one write and one read per cycle
// reset: palette and scale to defaults, scan to frame start, then a clearing
// pass zeroes all SRC_WIDTH*SRC_HEIGHT entries (23040 by default) of the
// screen memory while in_stall is held high
module palette_scanout_scaler #(
    parameter int SRC_WIDTH = 160,
    parameter int SRC_HEIGHT = 144,
    parameter int MAX_SCALE = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  pss_pkg::in_item_t               in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output pss_pkg::out_item_t              out_item,
    input  logic                            cfg_write,
    input  logic [pss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pss_pkg::*;

    localparam int DEPTH  = SRC_WIDTH * SRC_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [COLOR_W-1:0]     palette_reg [PALETTE_SIZE];
    logic [COLOR_W-1:0]     palette_next [PALETTE_SIZE];
    logic [SCALE_REG_W-1:0] scale_reg, scale_next;
    logic                   restart;

    logic              clear_reg, clear_next;
    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;

    logic        in_acc;
    logic        wr_acc;
    logic        fetch_acc;
    logic [31:0] idx_wide;
    logic        idx_ok;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CODE_W-1:0] ram_wdata;
    logic [CODE_W-1:0] ram_rdata;
    logic [ADDR_W-1:0] scan_addr;
    scan_pos_t         scan_pos;

    logic      s1_valid_reg, s1_valid_next;
    scan_pos_t s1_pos_reg;
    logic      s1_go;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    // configuration writes
    always_comb
    begin
        for (int i = 0; i < PALETTE_SIZE; i++)
        begin
            palette_next[i] = palette_reg[i];
        end
        scale_next = scale_reg;
        restart    = 1'b0;
        if (cfg_write)
        begin
            case (cfg_reg_e_t'(cfg_index))
                REG_WHITE: palette_next[0] = cfg_data[COLOR_W-1:0];
                REG_LIGHT: palette_next[1] = cfg_data[COLOR_W-1:0];
                REG_DARK:  palette_next[2] = cfg_data[COLOR_W-1:0];
                REG_BLACK: palette_next[3] = cfg_data[COLOR_W-1:0];
                REG_SCALE:
                begin
                    scale_next = cfg_data[SCALE_REG_W-1:0];
                    restart    = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_reg[0] <= WHITE_RESET;
            palette_reg[1] <= LIGHT_RESET;
            palette_reg[2] <= DARK_RESET;
            palette_reg[3] <= BLACK_RESET;
            scale_reg      <= SCALE_RESET;
        end
        else
        begin
            for (int i = 0; i < PALETTE_SIZE; i++)
            begin
                palette_reg[i] <= palette_next[i];
            end
            scale_reg <= scale_next;
        end
    end

    // input handshake, held off while clearing or when both stages are full and the output is stalled
    assign in_stall  = clear_reg || (s1_valid_reg && out_valid_reg && out_stall);
    assign in_acc    = in_valid && !in_stall;
    assign wr_acc    = in_acc && (in_item.func == FUNC_WRITE);
    assign fetch_acc = in_acc && (in_item.func == FUNC_FETCH);
    assign idx_wide  = 32'(in_item.pixel_index);
    assign idx_ok    = idx_wide < 32'(DEPTH);

    // clearing pass after reset
    always_comb
    begin
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_reg)
        begin
            if (32'(clear_addr_reg) == 32'(DEPTH - 1))
            begin
                clear_next      = 1'b0;
                clear_addr_next = '0;
            end
            else
            begin
                clear_addr_next = clear_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    // screen memory write port: clearing or write beats
    always_comb
    begin
        if (clear_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = wr_acc && idx_ok;
            ram_waddr = idx_wide[ADDR_W-1:0];
            ram_wdata = in_item.pixel_code;
        end
    end

    pss_ram #(
        .WIDTH  (CODE_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (fetch_acc),
        .raddr (scan_addr),
        .rdata (ram_rdata)
    );

    pss_scan #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .MAX_SCALE  (MAX_SCALE),
        .ADDR_W     (ADDR_W)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .scale   (scale_reg),
        .advance (fetch_acc),
        .addr    (scan_addr),
        .pos     (scan_pos)
    );

    // read stage: waits on memory data, holds while output is blocked
    assign s1_go         = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_valid_next = fetch_acc || (s1_valid_reg && !s1_go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch_acc)
        begin
            s1_pos_reg <= scan_pos;
        end
    end

    // output register with palette lookup
    assign out_valid_next = s1_go || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            out_item_reg.color        <= palette_reg[ram_rdata];
            out_item_reg.end_of_row   <= s1_pos_reg.end_of_row;
            out_item_reg.end_of_frame <= s1_pos_reg.end_of_frame;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // no write or fetch beat is accepted while the clearing pass runs
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !fetch_acc && !wr_acc)
        else $error("beat accepted during clearing pass");

    // an accepted fetch always lands in the read stage
    assert property (@(posedge clk) disable iff (!rst_n)
        fetch_acc |=> s1_valid_reg)
        else $error("fetch beat lost before read stage");

    // a blocked read stage keeps its memory data
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> $stable(ram_rdata) && s1_valid_reg)
        else $error("read stage data changed while held");

    // frame end only ever comes with row end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.end_of_frame |-> out_item_reg.end_of_row)
        else $error("frame end without row end");

endmodule

// File: sv/pss_ram.sv
`timescale 1ns / 1ps

module pss_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 23040,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/pss_scan.sv
`timescale 1ns / 1ps

module pss_scan #(
    parameter int SRC_WIDTH = 160,
    parameter int SRC_HEIGHT = 144,
    parameter int MAX_SCALE = 8,
    parameter int ADDR_W = 15
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            restart,
    input  logic [pss_pkg::SCALE_REG_W-1:0] scale,
    input  logic                            advance,
    output logic [ADDR_W-1:0]               addr,
    output pss_pkg::scan_pos_t              pos
);
    import pss_pkg::*;

    localparam int COL_W = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
    localparam int ROW_W = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
    localparam int REP_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [REP_W-1:0]  col_rep_reg, col_rep_next;
    logic [REP_W-1:0]  row_rep_reg, row_rep_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;

    logic [31:0] scale_wide;
    logic [31:0] eff_scale;
    logic        last_col;
    logic        last_row;
    logic        eor;
    logic        eof;

    // effective scale: zero acts as one, clamp at the maximum
    always_comb
    begin
        scale_wide = 32'(scale);
        if (scale_wide == 32'd0)
        begin
            eff_scale = 32'd1;
        end
        else if (scale_wide > 32'(MAX_SCALE))
        begin
            eff_scale = 32'(MAX_SCALE);
        end
        else
        begin
            eff_scale = scale_wide;
        end
    end

    // position flags
    assign last_col = (32'(col_rep_reg) + 32'd1) >= eff_scale;
    assign last_row = (32'(row_rep_reg) + 32'd1) >= eff_scale;
    assign eor      = last_col && ((32'(col_reg) + 32'd1) >= 32'(SRC_WIDTH));
    assign eof      = eor && last_row && ((32'(row_reg) + 32'd1) >= 32'(SRC_HEIGHT));

    // scan step, address kept as a running pointer
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        col_rep_next  = col_rep_reg;
        row_rep_next  = row_rep_reg;
        addr_next     = addr_reg;
        row_base_next = row_base_reg;
        if (restart)
        begin
            col_next      = '0;
            row_next      = '0;
            col_rep_next  = '0;
            row_rep_next  = '0;
            addr_next     = '0;
            row_base_next = '0;
        end
        else if (advance)
        begin
            if (!last_col)
            begin
                col_rep_next = col_rep_reg + 1'b1;
            end
            else if (!eor)
            begin
                col_rep_next = '0;
                col_next     = col_reg + 1'b1;
                addr_next    = addr_reg + 1'b1;
            end
            else if (!last_row)
            begin
                // repeat the same source row
                col_rep_next = '0;
                col_next     = '0;
                row_rep_next = row_rep_reg + 1'b1;
                addr_next    = row_base_reg;
            end
            else if (!eof)
            begin
                col_rep_next  = '0;
                col_next      = '0;
                row_rep_next  = '0;
                row_next      = row_reg + 1'b1;
                addr_next     = addr_reg + 1'b1;
                row_base_next = addr_reg + 1'b1;
            end
            else
            begin
                // wrap to frame start
                col_rep_next  = '0;
                col_next      = '0;
                row_rep_next  = '0;
                row_next      = '0;
                addr_next     = '0;
                row_base_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            col_rep_reg  <= '0;
            row_rep_reg  <= '0;
            addr_reg     <= '0;
            row_base_reg <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            col_rep_reg  <= col_rep_next;
            row_rep_reg  <= row_rep_next;
            addr_reg     <= addr_next;
            row_base_reg <= row_base_next;
        end
    end

    assign addr             = addr_reg;
    assign pos.end_of_row   = eor;
    assign pos.end_of_frame = eof;

    // pointer tracks row base plus column
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(addr_reg) == 32'(row_base_reg) + 32'(col_reg))
        else $error("scan pointer out of step with column");

    // counters stay inside the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < 32'(SRC_WIDTH)) && (32'(row_reg) < 32'(SRC_HEIGHT)))
        else $error("scan position beyond screen");

    // frame end wraps the pointer to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && eof && !restart) |=> (addr_reg == '0) && (row_base_reg == '0))
        else $error("scan did not wrap at frame end");

endmodule
